// ===== hdl/imu_complementary_filter_core_assert.svh =====
// assertion macros shared by the filter rtl
`ifndef IMU_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH
`define IMU_COMPLEMENTARY_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define ICF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ICF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/icf_pkg.sv =====
// types, constants and tables of the complementary filter
`default_nettype none

package icf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ANGLE_FRAC = 16;
   localparam int ANGLE_W    = 26;
   localparam int GAIN_W     = 16;
   localparam int WEIGHT_W   = 17;
   localparam int DT_W       = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_WEIGHT = 2'd1;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd500;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd1311;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

   // cordic datapath
   localparam int CORDIC_PRE = 30;
   localparam int CW         = SAMPLE_W + CORDIC_PRE + 3;
   localparam int TAB_IDX_W  = 5;
   localparam int TAB_FRAC   = 24;
   localparam int TAB_SH     = TAB_FRAC - ANGLE_FRAC;
   localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE = 26'sd5898240;

   // gyro path: mag * gain, then * dt, then / 1e6
   localparam int PROD1_W = SAMPLE_W + GAIN_W;
   localparam int PROD2_W = PROD1_W + DT_W;
   localparam int QUO_W   = 28;
   localparam int REM_W   = PROD2_W - QUO_W;
   localparam logic [REM_W-1:0]   US_PER_S = 20'd1000000;
   localparam logic [PROD2_W-1:0] HALF_US  = 48'd500000;

   // blend product
   localparam int DIFF_W = ANGLE_W + 1;
   localparam int BPROD_W = DIFF_W + WEIGHT_W;
   localparam int SUM_W   = BPROD_W + 1;
   localparam logic signed [SUM_W-1:0] BLEND_HALF = 45'sd32768;

   localparam int MUL_STEPS   = GAIN_W;
   localparam int DIV_STEPS   = QUO_W;
   localparam int BLEND_STEPS = WEIGHT_W;
   localparam int STEP_W      = 5;

   localparam int LANE_PITCH = 0;
   localparam int LANE_ROLL  = 1;
   localparam int LANE_YAW   = 2;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_MUL1  = 10'b0000000010,
      ST_MUL2  = 10'b0000000100,
      ST_PREP  = 10'b0000001000,
      ST_DIV   = 10'b0000010000,
      ST_ACCUM = 10'b0000100000,
      ST_BLOAD = 10'b0001000000,
      ST_BLEND = 10'b0010000000,
      ST_BFIN  = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   // arctangent of 2^-idx in degrees, rounded to the angle fraction
   function automatic logic signed [ANGLE_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
      logic [31:0] raw;
      case (idx)
         5'd0:  raw = 32'd754974720;
         5'd1:  raw = 32'd445687602;
         5'd2:  raw = 32'd235489088;
         5'd3:  raw = 32'd119537938;
         5'd4:  raw = 32'd60000934;
         5'd5:  raw = 32'd30029717;
         5'd6:  raw = 32'd15018523;
         5'd7:  raw = 32'd7509720;
         5'd8:  raw = 32'd3754917;
         5'd9:  raw = 32'd1877466;
         5'd10: raw = 32'd938734;
         5'd11: raw = 32'd469367;
         5'd12: raw = 32'd234684;
         5'd13: raw = 32'd117342;
         5'd14: raw = 32'd58671;
         5'd15: raw = 32'd29335;
         5'd16: raw = 32'd14668;
         5'd17: raw = 32'd7334;
         5'd18: raw = 32'd3667;
         5'd19: raw = 32'd1833;
         5'd20: raw = 32'd917;
         5'd21: raw = 32'd458;
         5'd22: raw = 32'd229;
         5'd23: raw = 32'd115;
         default: raw = 32'd0;
      endcase
      return ANGLE_W'((raw + (32'd1 << (TAB_SH - 1))) >> TAB_SH);
   endfunction

   // clamp to the angle range
   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(33554431);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return ANGLE_W'(hi);
      end else if (v < lo) begin
         return ANGLE_W'(lo);
      end
      return ANGLE_W'(v);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/imu_complementary_filter_core.sv =====
// imu complementary filter: gyro integration with accelerometer blend
//
//   channel  dir  beat contents                               handshake
//   req      in   accel x/y/z, gyro x/y/z, elapsed_us         req_valid / req_stall
//   rsp      out  pitch_out, roll_out, yaw_out                rsp_valid / rsp_stall
//   csr      in   gyro_gain (0), accel_weight (1)             csr_write_en
//
// req_stall holds off a new sample until the last one reaches the result register
// shift-add multipliers (gain, then elapsed time), a restoring divide by 1e6 and a
// shift-add blend multiply make up the sequence; cordic runs alongside the multipliers
// reset is synchronous and restores the angles and the register defaults
// a new sample is taken while a finished result still waits on rsp_stall
`default_nettype none

module imu_complementary_filter_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_en,
   input  logic [icf_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [icf_pkg::CSR_DATA_W-1:0]            csr_wdata,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [icf_pkg::SAMPLE_W-1:0]       req_accel_x,
   input  logic signed [icf_pkg::SAMPLE_W-1:0]       req_accel_y,
   input  logic signed [icf_pkg::SAMPLE_W-1:0]       req_accel_z,
   input  logic signed [icf_pkg::SAMPLE_W-1:0]       req_gyro_x,
   input  logic signed [icf_pkg::SAMPLE_W-1:0]       req_gyro_y,
   input  logic signed [icf_pkg::SAMPLE_W-1:0]       req_gyro_z,
   input  logic [icf_pkg::DT_W-1:0]                  req_elapsed_us,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [icf_pkg::ANGLE_W-1:0]        rsp_pitch_out,
   output logic signed [icf_pkg::ANGLE_W-1:0]        rsp_roll_out,
   output logic signed [icf_pkg::ANGLE_W-1:0]        rsp_yaw_out
);

`include "imu_complementary_filter_core_assert.svh"

   localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
   localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS);

   localparam int SW  = icf_pkg::SAMPLE_W;
   localparam int AW  = icf_pkg::ANGLE_W;
   localparam int CW  = icf_pkg::CW;
   localparam int P1W = icf_pkg::PROD1_W;
   localparam int P2W = icf_pkg::PROD2_W;
   localparam int QW  = icf_pkg::QUO_W;
   localparam int RW  = icf_pkg::REM_W;
   localparam int DW  = icf_pkg::DIFF_W;
   localparam int BW  = icf_pkg::BPROD_W;
   localparam int WW  = icf_pkg::WEIGHT_W;
   localparam int XW  = icf_pkg::SUM_W;

   // control
   icf_pkg::state_type state_ff, state_in;
   logic [icf_pkg::STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] ccnt_ff, ccnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [icf_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [WW-1:0] weight_ff, weight_in;
   logic signed [AW-1:0] angle_ff [3];
   logic signed [AW-1:0] angle_in [3];

   // payload
   logic [icf_pkg::DT_W-1:0] dt_ff, dt_in;
   logic [SW-1:0] mag_ff [3];
   logic [SW-1:0] mag_in [3];
   logic neg_ff [3];
   logic neg_in [3];
   logic [P1W-1:0] p1_ff [3];
   logic [P1W-1:0] p1_in [3];
   logic [P2W-1:0] p2_ff [3];
   logic [P2W-1:0] p2_in [3];
   logic signed [CW-1:0] cx_ff [2];
   logic signed [CW-1:0] cx_in [2];
   logic signed [CW-1:0] cy_ff [2];
   logic signed [CW-1:0] cy_in [2];
   logic signed [AW-1:0] cz_ff [2];
   logic signed [AW-1:0] cz_in [2];
   logic czero_ff [2];
   logic czero_in [2];
   logic signed [DW-1:0] bd_ff [2];
   logic signed [DW-1:0] bd_in [2];
   logic signed [BW-1:0] bp_ff [2];
   logic signed [BW-1:0] bp_in [2];
   logic signed [AW-1:0] rsp_pitch_ff, rsp_pitch_in;
   logic signed [AW-1:0] rsp_roll_ff, rsp_roll_in;
   logic signed [AW-1:0] rsp_yaw_ff, rsp_yaw_in;

   // per-lane working values
   logic signed [SW-1:0] gyro_sel [3];
   logic signed [SW-1:0] accel_sel [2];
   logic [SW:0] m1_add [3];
   logic [P1W:0] m2_add [3];
   logic [RW:0] div_t [3];
   logic div_ge [3];
   logic [RW-1:0] div_r [3];
   logic signed [XW-1:0] q_ext [3];
   logic signed [CW-1:0] ld_x [2];
   logic signed [CW-1:0] ld_y [2];
   logic signed [AW-1:0] tab_val;
   logic signed [AW-1:0] acc_ang [2];
   logic signed [DW:0] b_add [2];
   logic signed [XW-1:0] b_sum [2];
   logic [WW-1:0] w_eff;
   logic req_accept;

   assign req_stall  = (state_ff != icf_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pitch_out = rsp_pitch_ff;
   assign rsp_roll_out  = rsp_roll_ff;
   assign rsp_yaw_out   = rsp_yaw_ff;

   always_comb begin
      gyro_sel[icf_pkg::LANE_PITCH]  = req_gyro_y;
      gyro_sel[icf_pkg::LANE_ROLL]   = req_gyro_x;
      gyro_sel[icf_pkg::LANE_YAW]    = req_gyro_z;
      accel_sel[icf_pkg::LANE_PITCH] = req_accel_x;
      accel_sel[icf_pkg::LANE_ROLL]  = req_accel_y;
      w_eff   = (weight_ff > icf_pkg::WEIGHT_ONE) ? icf_pkg::WEIGHT_ONE : weight_ff;
      tab_val = icf_pkg::atan_deg(icf_pkg::TAB_IDX_W'(ccnt_ff));

      state_in     = state_ff;
      step_in      = step_ff;
      ccnt_in      = ccnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      gain_in      = gain_ff;
      weight_in    = weight_ff;
      dt_in        = dt_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_roll_in  = rsp_roll_ff;
      rsp_yaw_in   = rsp_yaw_ff;

      for (int i = 0; i < 3; i++) begin
         angle_in[i] = angle_ff[i];
         mag_in[i]   = mag_ff[i];
         neg_in[i]   = neg_ff[i];
         p1_in[i]    = p1_ff[i];
         p2_in[i]    = p2_ff[i];
         m1_add[i] = {1'b0, p1_ff[i][P1W-1:SW]} + (p1_ff[i][0] ? {1'b0, mag_ff[i]} : '0);
         m2_add[i] = {1'b0, p2_ff[i][P2W-1:icf_pkg::DT_W]}
                   + (p2_ff[i][0] ? {1'b0, p1_ff[i]} : '0);
         div_t[i]  = {p2_ff[i][P2W-1:QW], p2_ff[i][QW-1]};
         div_ge[i] = (div_t[i] >= {1'b0, icf_pkg::US_PER_S});
         div_r[i]  = div_ge[i] ? RW'(div_t[i] - {1'b0, icf_pkg::US_PER_S}) : div_t[i][RW-1:0];
         q_ext[i]  = neg_ff[i] ? -$signed(XW'(p2_ff[i][QW-1:0]))
                               : $signed(XW'(p2_ff[i][QW-1:0]));
      end

      for (int c = 0; c < 2; c++) begin
         cx_in[c]    = cx_ff[c];
         cy_in[c]    = cy_ff[c];
         cz_in[c]    = cz_ff[c];
         czero_in[c] = czero_ff[c];
         bd_in[c]    = bd_ff[c];
         bp_in[c]    = bp_ff[c];
         ld_x[c] = $signed(CW'(req_accel_z)) <<< icf_pkg::CORDIC_PRE;
         ld_y[c] = $signed(CW'(accel_sel[c])) <<< icf_pkg::CORDIC_PRE;
         acc_ang[c] = czero_ff[c] ? '0 : ((c == icf_pkg::LANE_ROLL) ? -cz_ff[c] : cz_ff[c]);
         b_add[c] = $signed({bp_ff[c][BW-1], bp_ff[c][BW-1:WW]})
                  + (bp_ff[c][0] ? $signed({bd_ff[c][DW-1], bd_ff[c]}) : '0);
         b_sum[c] = ($signed(XW'(angle_ff[c])) <<< icf_pkg::ANGLE_FRAC)
                  + $signed(XW'(bp_ff[c])) + icf_pkg::BLEND_HALF;
      end

      // cordic iterations run free of the main sequence
      if (ccnt_ff != CORDIC_LAST) begin
         for (int c = 0; c < 2; c++) begin
            if (!cy_ff[c][CW-1]) begin
               cx_in[c] = cx_ff[c] + (cy_ff[c] >>> ccnt_ff);
               cy_in[c] = cy_ff[c] - (cx_ff[c] >>> ccnt_ff);
               cz_in[c] = cz_ff[c] + tab_val;
            end else begin
               cx_in[c] = cx_ff[c] - (cy_ff[c] >>> ccnt_ff);
               cy_in[c] = cy_ff[c] + (cx_ff[c] >>> ccnt_ff);
               cz_in[c] = cz_ff[c] - tab_val;
            end
         end
         ccnt_in = ccnt_ff + CNT_W'(1);
      end

      case (state_ff)
         icf_pkg::ST_IDLE: begin
            if (req_accept) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = gyro_sel[i][SW-1];
                  mag_in[i] = gyro_sel[i][SW-1] ? SW'(-gyro_sel[i]) : SW'(gyro_sel[i]);
                  p1_in[i]  = {SW'(0), gain_ff};
               end
               for (int c = 0; c < 2; c++) begin
                  czero_in[c] = (req_accel_z == '0) && (accel_sel[c] == '0);
                  // left half plane: rotate by a right angle first
                  if (ld_x[c][CW-1]) begin
                     if (!ld_y[c][CW-1]) begin
                        cx_in[c] = ld_y[c];
                        cy_in[c] = -ld_x[c];
                        cz_in[c] = icf_pkg::RIGHT_ANGLE;
                     end else begin
                        cx_in[c] = -ld_y[c];
                        cy_in[c] = ld_x[c];
                        cz_in[c] = -icf_pkg::RIGHT_ANGLE;
                     end
                  end else begin
                     cx_in[c] = ld_x[c];
                     cy_in[c] = ld_y[c];
                     cz_in[c] = '0;
                  end
               end
               dt_in    = req_elapsed_us;
               ccnt_in  = '0;
               step_in  = '0;
               state_in = icf_pkg::ST_MUL1;
            end
         end
         icf_pkg::ST_MUL1: begin
            for (int i = 0; i < 3; i++) begin
               p1_in[i] = {m1_add[i], p1_ff[i][SW-1:1]};
            end
            step_in = step_ff + icf_pkg::STEP_W'(1);
            if (step_ff == icf_pkg::STEP_W'(icf_pkg::MUL_STEPS - 1)) begin
               for (int i = 0; i < 3; i++) begin
                  p2_in[i] = {P1W'(0), dt_ff};
               end
               step_in  = '0;
               state_in = icf_pkg::ST_MUL2;
            end
         end
         icf_pkg::ST_MUL2: begin
            for (int i = 0; i < 3; i++) begin
               p2_in[i] = {m2_add[i], p2_ff[i][icf_pkg::DT_W-1:1]};
            end
            step_in = step_ff + icf_pkg::STEP_W'(1);
            if (step_ff == icf_pkg::STEP_W'(icf_pkg::MUL_STEPS - 1)) begin
               step_in  = '0;
               state_in = icf_pkg::ST_PREP;
            end
         end
         icf_pkg::ST_PREP: begin
            // round to nearest before the divide
            for (int i = 0; i < 3; i++) begin
               p2_in[i] = p2_ff[i] + icf_pkg::HALF_US;
            end
            state_in = icf_pkg::ST_DIV;
         end
         icf_pkg::ST_DIV: begin
            // quotient bits shift into the low end, remainder sits on top
            for (int i = 0; i < 3; i++) begin
               p2_in[i] = {div_r[i], p2_ff[i][QW-2:0], div_ge[i]};
            end
            step_in = step_ff + icf_pkg::STEP_W'(1);
            if (step_ff == icf_pkg::STEP_W'(icf_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = icf_pkg::ST_ACCUM;
            end
         end
         icf_pkg::ST_ACCUM: begin
            for (int i = 0; i < 3; i++) begin
               angle_in[i] = icf_pkg::sat_angle($signed(XW'(angle_ff[i])) + q_ext[i]);
            end
            state_in = icf_pkg::ST_BLOAD;
         end
         icf_pkg::ST_BLOAD: begin
            for (int c = 0; c < 2; c++) begin
               bd_in[c] = $signed(DW'(acc_ang[c])) - $signed(DW'(angle_ff[c]));
               bp_in[c] = $signed({DW'(0), w_eff});
            end
            step_in  = '0;
            state_in = icf_pkg::ST_BLEND;
         end
         icf_pkg::ST_BLEND: begin
            for (int c = 0; c < 2; c++) begin
               bp_in[c] = $signed({b_add[c], bp_ff[c][WW-1:1]});
            end
            step_in = step_ff + icf_pkg::STEP_W'(1);
            if (step_ff == icf_pkg::STEP_W'(icf_pkg::BLEND_STEPS - 1)) begin
               step_in  = '0;
               state_in = icf_pkg::ST_BFIN;
            end
         end
         icf_pkg::ST_BFIN: begin
            for (int c = 0; c < 2; c++) begin
               angle_in[c] = icf_pkg::sat_angle(b_sum[c] >>> icf_pkg::ANGLE_FRAC);
            end
            state_in = icf_pkg::ST_DONE;
         end
         icf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_pitch_in = angle_ff[icf_pkg::LANE_PITCH];
               rsp_roll_in  = angle_ff[icf_pkg::LANE_ROLL];
               rsp_yaw_in   = angle_ff[icf_pkg::LANE_YAW];
               rsp_valid_in = 1'b1;
               state_in     = icf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = icf_pkg::ST_IDLE;
         end
      endcase

      if (csr_write_en) begin
         case (csr_index)
            icf_pkg::CSR_GYRO_GAIN: begin
               gain_in = csr_wdata[icf_pkg::GAIN_W-1:0];
            end
            icf_pkg::CSR_ACCEL_WEIGHT: begin
               weight_in = csr_wdata[WW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= icf_pkg::ST_IDLE;
         step_ff      <= '0;
         ccnt_ff      <= CORDIC_LAST;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= icf_pkg::GAIN_RESET;
         weight_ff    <= icf_pkg::WEIGHT_RESET;
         for (int i = 0; i < 3; i++) begin
            angle_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ccnt_ff      <= ccnt_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         weight_ff    <= weight_in;
         for (int i = 0; i < 3; i++) begin
            angle_ff[i] <= angle_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= mag_in[i];
         neg_ff[i] <= neg_in[i];
         p1_ff[i]  <= p1_in[i];
         p2_ff[i]  <= p2_in[i];
      end
      for (int c = 0; c < 2; c++) begin
         cx_ff[c]    <= cx_in[c];
         cy_ff[c]    <= cy_in[c];
         cz_ff[c]    <= cz_in[c];
         czero_ff[c] <= czero_in[c];
         bd_ff[c]    <= bd_in[c];
         bp_ff[c]    <= bp_in[c];
      end
   end

   `ICF_ASSERT_NOW(a_cordic_ready, clock, reset, state_ff == icf_pkg::ST_ACCUM, ccnt_ff == CORDIC_LAST, "cordic still busy at accumulate")
   `ICF_ASSERT_NOW(a_rem_bound, clock, reset, state_ff == icf_pkg::ST_DIV, p2_ff[icf_pkg::LANE_YAW][P2W-1:QW] < icf_pkg::US_PER_S, "divide remainder out of range")
   `ICF_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == icf_pkg::ST_MUL1, "accepted beat did not start the multiply")
   `ICF_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == icf_pkg::ST_DONE, "result raised outside the done state")

endmodule

`default_nettype wire
